// ===== rtl/mtx2_alu_pkg.sv =====
`timescale 1ns / 1ps
package mtx2_alu_pkg;

  // Fixed-point format and derived widths
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int DM_W      = PROD_W;
  localparam int QW        = DATA_W;
  localparam int NW        = DATA_W + 2 * FRAC_BITS;
  localparam int DIV_LAT   = QW + 3;
  localparam int THR_W     = 31;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [THR_W-1:0]         THR_RESET = THR_W'(66);
  localparam logic [SUM_W:0]           RND_HALF = (SUM_W+1)'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_DIV   = 4'd3,
    OP_MVEC  = 4'd4,
    OP_MMUL  = 4'd5,
    OP_INV   = 4'd6,
    OP_XINVY = 4'd7,
    OP_SING  = 4'd8
  } op_t;

  // Request into one divider lane
  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DM_W-1:0]         dm;
    logic                    den_neg;
    logic                    wide;
  } div_req_t;

  // Result out of one divider lane
  typedef struct packed {
    logic signed [DATA_W-1:0] quo;
    logic                     fault;
  } div_rsp_t;

  // Saturate a 33-bit value to the 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_narrow(input logic signed [NUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[NUM_W-1] != v[NUM_W-2]) begin
      r = v[NUM_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Round to nearest (ties up), drop the fraction, saturate
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W:0]    v;
    logic signed [SUM_W:0]    sh;
    logic signed [DATA_W-1:0] r;
    v  = {s[SUM_W-1], s} + RND_HALF;
    sh = v >>> FRAC_BITS;
    if (!sh[SUM_W] && (|sh[SUM_W-1:DATA_W-1])) begin
      r = SAT_MAX;
    end else if (sh[SUM_W] && !(&sh[SUM_W-1:DATA_W-1])) begin
      r = SAT_MIN;
    end else begin
      r = sh[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/mtx2_alu_div.sv =====
`timescale 1ns / 1ps
module mtx2_alu_div import mtx2_alu_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  div_req_t req,
  output div_rsp_t rsp
);

  typedef struct packed {
    logic neg;
    logic npos;
    logic nneg;
    logic dz;
    logic ovf;
  } div_ctl_t;

  localparam logic [QW:0] Q_LIM = (QW+1)'(1) << (DATA_W - 1);

  logic [NUM_W-1:0] num_mag;
  logic [NW-1:0]    n_shift;
  logic [NW-1:0]    d0_n;
  logic [DM_W-1:0]  d0_dm;
  div_ctl_t         d0_ctl;
  div_ctl_t         d1_ctl;
  logic [DM_W-1:0]  rem0;

  logic [DM_W-1:0]  st_rem [QW+1];
  logic [QW-1:0]    st_lo  [QW+1];
  logic [QW-1:0]    st_q   [QW+1];
  logic [DM_W-1:0]  st_dm  [QW+1];
  div_ctl_t         st_ctl [QW+1];

  logic             round_up;
  logic [QW:0]      qr;
  logic [QW:0]      qneg;
  div_rsp_t         rsp_next;

  // Scale the numerator magnitude by the fraction shift
  always_comb begin
    num_mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : req.num;
    if (req.wide) begin
      n_shift = {num_mag[DATA_W-1:0], {(2*FRAC_BITS){1'b0}}};
    end else begin
      n_shift = NW'({num_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_n   <= n_shift;
      d0_dm  <= req.dm;
      d0_ctl <= '{neg:  req.num[NUM_W-1] ^ req.den_neg,
                  npos: !req.num[NUM_W-1] && (|req.num),
                  nneg: req.num[NUM_W-1],
                  dz:   ~|req.dm,
                  ovf:  1'b0};
    end
  end

  // Flag quotients too large for the quotient register, load the first remainder
  always_comb begin
    rem0       = DM_W'(d0_n[NW-1:QW]);
    d1_ctl     = d0_ctl;
    d1_ctl.ovf = rem0 >= d0_dm;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_rem[0] <= rem0;
      st_lo[0]  <= d0_n[QW-1:0];
      st_q[0]   <= '0;
      st_dm[0]  <= d0_dm;
      st_ctl[0] <= d1_ctl;
    end
  end

  // One restoring step per stage, one quotient bit each
  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [DM_W:0] trial;
    logic          ge;
    assign trial = {st_rem[g], st_lo[g][QW-1]};
    assign ge    = trial >= {1'b0, st_dm[g]};
    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[g+1] <= ge ? DM_W'(trial - {1'b0, st_dm[g]}) : trial[DM_W-1:0];
        st_lo[g+1]  <= st_lo[g] << 1;
        st_q[g+1]   <= {st_q[g][QW-2:0], ge};
        st_dm[g+1]  <= st_dm[g];
        st_ctl[g+1] <= st_ctl[g];
      end
    end
  end

  // Round on the remainder, then saturate and apply the sign
  always_comb begin
    round_up       = {st_rem[QW], 1'b0} >= {1'b0, st_dm[QW]};
    qr             = {1'b0, st_q[QW]} + (QW+1)'(round_up);
    qneg           = (QW+1)'(0) - qr;
    rsp_next.fault = st_ctl[QW].dz;
    priority if (st_ctl[QW].dz) begin
      rsp_next.quo = st_ctl[QW].npos ? SAT_MAX : (st_ctl[QW].nneg ? SAT_MIN : '0);
    end else if (!st_ctl[QW].npos && !st_ctl[QW].nneg) begin
      rsp_next.quo = '0;
    end else if (st_ctl[QW].ovf || (qr > Q_LIM)) begin
      rsp_next.quo = st_ctl[QW].neg ? SAT_MIN : SAT_MAX;
    end else if (st_ctl[QW].neg) begin
      rsp_next.quo = qneg[DATA_W-1:0];
    end else if (qr == Q_LIM) begin
      rsp_next.quo = SAT_MAX;
    end else begin
      rsp_next.quo = qr[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== rtl/matrix2x2_fixed_alu_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   operation, x_a..x_d, y_a..y_d
// result    out        out_valid/out_stall out_a..out_d, singular, divide_fault
// config    in         psel/penable/pready singular_threshold at byte address 0
//
// One item enters per clock cycle while in_stall is low.
// Latency is set by the four divider lanes: 32 restoring stages, one quotient bit each.
// Synchronous reset clears all valid bits and loads the threshold with 66.
// A stalled result freezes the whole pipeline; no item is dropped or repeated.
module matrix2x2_fixed_alu_core import mtx2_alu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               operation,
  input  logic signed [DATA_W-1:0] x_a,
  input  logic signed [DATA_W-1:0] x_b,
  input  logic signed [DATA_W-1:0] x_c,
  input  logic signed [DATA_W-1:0] x_d,
  input  logic signed [DATA_W-1:0] y_a,
  input  logic signed [DATA_W-1:0] y_b,
  input  logic signed [DATA_W-1:0] y_c,
  input  logic signed [DATA_W-1:0] y_d,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_a,
  output logic signed [DATA_W-1:0] out_b,
  output logic signed [DATA_W-1:0] out_c,
  output logic signed [DATA_W-1:0] out_d,
  output logic                     singular,
  output logic                     divide_fault,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int         N_EL   = 4;
  localparam int         N_PROD = 8;
  localparam int         PA [N_PROD] = '{0, 1, 0, 1, 2, 3, 2, 3};
  localparam int         PB [N_PROD] = '{0, 2, 1, 3, 0, 2, 1, 3};
  localparam logic [0:0] CFG_THR = 1'b0;

  logic             adv;
  logic             cfg_wr;
  logic [THR_W-1:0] thr;

  logic                     s1_valid;
  op_t                      s1_op;
  logic signed [DATA_W-1:0] s1_x [N_EL];
  logic signed [DATA_W-1:0] s1_y [N_EL];

  logic signed [DATA_W-1:0] ma [N_PROD];
  logic signed [DATA_W-1:0] mb [N_PROD];
  logic signed [DATA_W-1:0] as_next [N_EL];

  logic                     s2_valid;
  op_t                      s2_op;
  logic signed [DATA_W-1:0] s2_x [N_EL];
  logic signed [DATA_W-1:0] s2_y [N_EL];
  logic signed [PROD_W-1:0] s2_p [N_PROD];
  logic signed [DATA_W-1:0] s2_as [N_EL];

  logic                     s3_valid;
  op_t                      s3_op;
  logic signed [DATA_W-1:0] s3_x [N_EL];
  logic signed [DATA_W-1:0] s3_y [N_EL];
  logic signed [SUM_W-1:0]  s3_sum [N_EL];
  logic [DM_W-1:0]          s3_det;
  logic signed [DATA_W-1:0] s3_as [N_EL];

  logic signed [DATA_W-1:0] inv_m [N_EL];
  logic signed [NUM_W-1:0]  inv_num [N_EL];
  logic [DM_W-1:0]          det_mag;
  logic [NUM_W-1:0]         y0_ext;
  logic [NUM_W-1:0]         y0_mag;
  logic                     sing_next;
  logic signed [DATA_W-1:0] er [N_EL];
  div_req_t                 div_req [N_EL];
  div_rsp_t                 div_rsp [N_EL];

  logic [DIV_LAT-1:0]       dl_valid;
  op_t                      dl_op   [DIV_LAT];
  logic signed [DATA_W-1:0] dl_r    [DIV_LAT][N_EL];
  logic signed [DATA_W-1:0] dl_x    [DIV_LAT][N_EL];
  logic                     dl_sing [DIV_LAT];

  logic                     p1_valid;
  op_t                      p1_op;
  logic signed [DATA_W-1:0] p1_r [N_EL];
  logic signed [DATA_W-1:0] p1_t [N_EL];
  logic signed [PROD_W-1:0] p1_p [N_PROD];
  logic                     p1_sing;
  logic                     p1_fault;

  logic                     p2_valid;
  op_t                      p2_op;
  logic signed [DATA_W-1:0] p2_r [N_EL];
  logic signed [DATA_W-1:0] p2_t [N_EL];
  logic signed [SUM_W-1:0]  p2_sum [N_EL];
  logic                     p2_sing;
  logic                     p2_fault;

  logic signed [DATA_W-1:0] fin [N_EL];

  // Whole pipeline moves unless a finished result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Configuration register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_THR) ? {1'b0, thr} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr && (paddr[2] == CFG_THR)) begin
      thr <= pwdata[THR_W-1:0];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      dl_valid  <= '0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      dl_valid  <= {dl_valid[DIV_LAT-2:0], s3_valid};
      p1_valid  <= dl_valid[DIV_LAT-1];
      p2_valid  <= p1_valid;
      out_valid <= p2_valid;
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op <= op_t'(operation);
      s1_x  <= '{x_a, x_b, x_c, x_d};
      s1_y  <= '{y_a, y_b, y_c, y_d};
    end
  end

  // Steer multiplier operands by operation
  always_comb begin
    for (int k = 0; k < N_PROD; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    unique case (s1_op)
      OP_SCALE: begin
        for (int k = 0; k < N_EL; k++) begin
          ma[2*k] = s1_x[k];
          mb[2*k] = s1_y[0];
        end
      end
      OP_MVEC: begin
        for (int k = 0; k < 2; k++) begin
          ma[2*k]   = s1_x[2*k];
          mb[2*k]   = s1_y[0];
          ma[2*k+1] = s1_x[2*k+1];
          mb[2*k+1] = s1_y[1];
        end
      end
      OP_MMUL: begin
        for (int k = 0; k < N_PROD; k++) begin
          ma[k] = s1_x[PA[k]];
          mb[k] = s1_y[PB[k]];
        end
      end
      OP_INV, OP_SING: begin
        ma[0] = s1_x[0];
        mb[0] = s1_x[3];
        ma[1] = s1_x[1];
        mb[1] = s1_x[2];
      end
      OP_XINVY: begin
        ma[0] = s1_y[0];
        mb[0] = s1_y[3];
        ma[1] = s1_y[1];
        mb[1] = s1_y[2];
      end
      default: ;
    endcase
    for (int k = 0; k < N_EL; k++) begin
      if (s1_op == OP_SUB) begin
        as_next[k] = sat_narrow({s1_x[k][DATA_W-1], s1_x[k]} - {s1_y[k][DATA_W-1], s1_y[k]});
      end else begin
        as_next[k] = sat_narrow({s1_x[k][DATA_W-1], s1_x[k]} + {s1_y[k][DATA_W-1], s1_y[k]});
      end
    end
  end

  // Products and element-wise add or subtract
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op <= s1_op;
      s2_x  <= s1_x;
      s2_y  <= s1_y;
      s2_as <= as_next;
      for (int k = 0; k < N_PROD; k++) begin
        s2_p[k] <= ma[k] * mb[k];
      end
    end
  end

  // Pair sums and determinant
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op  <= s2_op;
      s3_x   <= s2_x;
      s3_y   <= s2_y;
      s3_as  <= s2_as;
      s3_det <= DM_W'(s2_p[0] - s2_p[1]);
      for (int k = 0; k < N_EL; k++) begin
        s3_sum[k] <= {s2_p[2*k][PROD_W-1], s2_p[2*k]} + {s2_p[2*k+1][PROD_W-1], s2_p[2*k+1]};
      end
    end
  end

  // Divider requests, singular test and the results that need no division
  always_comb begin
    det_mag = s3_det[DM_W-1] ? DM_W'(-s3_det) : s3_det;
    y0_ext  = {s3_y[0][DATA_W-1], s3_y[0]};
    y0_mag  = y0_ext[NUM_W-1] ? NUM_W'(-y0_ext) : y0_ext;
    for (int k = 0; k < N_EL; k++) begin
      inv_m[k] = (s3_op == OP_XINVY) ? s3_y[k] : s3_x[k];
    end
    inv_num[0] = {inv_m[3][DATA_W-1], inv_m[3]};
    inv_num[1] = NUM_W'(-{inv_m[1][DATA_W-1], inv_m[1]});
    inv_num[2] = NUM_W'(-{inv_m[2][DATA_W-1], inv_m[2]});
    inv_num[3] = {inv_m[0][DATA_W-1], inv_m[0]};
    for (int k = 0; k < N_EL; k++) begin
      if (s3_op == OP_DIV) begin
        div_req[k].num     = {s3_x[k][DATA_W-1], s3_x[k]};
        div_req[k].dm      = DM_W'(y0_mag);
        div_req[k].den_neg = s3_y[0][DATA_W-1];
        div_req[k].wide    = 1'b0;
      end else begin
        div_req[k].num     = inv_num[k];
        div_req[k].dm      = det_mag;
        div_req[k].den_neg = s3_det[DM_W-1];
        div_req[k].wide    = 1'b1;
      end
      unique case (s3_op)
        OP_ADD, OP_SUB:             er[k] = s3_as[k];
        OP_SCALE, OP_MVEC, OP_MMUL: er[k] = round_sat(s3_sum[k]);
        default:                    er[k] = '0;
      endcase
    end
    sing_next = ((s3_op == OP_INV) || (s3_op == OP_XINVY) || (s3_op == OP_SING)) &&
                (det_mag < DM_W'({thr, {FRAC_BITS{1'b0}}}));
  end

  for (genvar g = 0; g < N_EL; g++) begin : g_div
    mtx2_alu_div u_div (
      .clk (clk),
      .en  (adv),
      .req (div_req[g]),
      .rsp (div_rsp[g])
    );
  end

  // Delay line alongside the divider lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      dl_op[0]   <= s3_op;
      dl_r[0]    <= er;
      dl_x[0]    <= s3_x;
      dl_sing[0] <= sing_next;
      for (int j = 1; j < DIV_LAT; j++) begin
        dl_op[j]   <= dl_op[j-1];
        dl_r[j]    <= dl_r[j-1];
        dl_x[j]    <= dl_x[j-1];
        dl_sing[j] <= dl_sing[j-1];
      end
    end
  end

  // X times the inverse: products
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_op    <= dl_op[DIV_LAT-1];
      p1_r     <= dl_r[DIV_LAT-1];
      p1_sing  <= dl_sing[DIV_LAT-1];
      p1_fault <= div_rsp[0].fault && ((dl_op[DIV_LAT-1] == OP_DIV) ||
                  (dl_op[DIV_LAT-1] == OP_INV) || (dl_op[DIV_LAT-1] == OP_XINVY));
      for (int k = 0; k < N_EL; k++) begin
        p1_t[k] <= div_rsp[k].quo;
      end
      for (int k = 0; k < N_PROD; k++) begin
        p1_p[k] <= dl_x[DIV_LAT-1][PA[k]] * div_rsp[PB[k]].quo;
      end
    end
  end

  // X times the inverse: pair sums
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_op    <= p1_op;
      p2_r     <= p1_r;
      p2_t     <= p1_t;
      p2_sing  <= p1_sing;
      p2_fault <= p1_fault;
      for (int k = 0; k < N_EL; k++) begin
        p2_sum[k] <= {p1_p[2*k][PROD_W-1], p1_p[2*k]} + {p1_p[2*k+1][PROD_W-1], p1_p[2*k+1]};
      end
    end
  end

  // Pick the final result
  always_comb begin
    for (int k = 0; k < N_EL; k++) begin
      unique case (p2_op)
        OP_XINVY:       fin[k] = round_sat(p2_sum[k]);
        OP_DIV, OP_INV: fin[k] = p2_t[k];
        default:        fin[k] = p2_r[k];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_a        <= fin[0];
      out_b        <= fin[1];
      out_c        <= fin[2];
      out_d        <= fin[3];
      singular     <= p2_sing;
      divide_fault <= p2_fault;
    end
  end

  // A held result freezes every stage; checked on the s1, delay-line and p2 valid bits
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(s1_valid) && $stable(dl_valid) && $stable(p2_valid)))
    else $error("pipeline moved while the result was held");

  // All lanes share one divisor, so their zero-divisor flags agree
  a_lane_fault: assert property (@(posedge clk) disable iff (rst)
    dl_valid[DIV_LAT-1] |-> (div_rsp[0].fault == div_rsp[N_EL-1].fault))
    else $error("divider lanes disagree on a zero divisor");

endmodule

// ===== bench/matrix2x2_fixed_alu_core_test.sv =====
`timescale 1ns / 1ps
module matrix2x2_fixed_alu_core_test;
  import mtx2_alu_pkg::*;

  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
  localparam int         HOLD_LEN       = 300;
  localparam int         SETTLE_CYCLES  = 60;
  localparam longint     CYCLE_LIMIT    = 400000;

  typedef logic signed [DATA_W-1:0] mat_t [4];

  typedef struct packed {
    logic [3:0]               op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
    logic                     sing;
    logic                     fault;
  } matrix_result_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [3:0] operation;
  logic signed [DATA_W-1:0] x_a, x_b, x_c, x_d, y_a, y_b, y_c, y_d;
  logic signed [DATA_W-1:0] out_a, out_b, out_c, out_d;
  logic singular, divide_fault;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  matrix_result_t  pending_results[$];
  logic [THR_W-1:0] thr_shadow;
  int     mismatches;
  longint cycle_count;
  bit     quiet;
  bit     hold_req;
  int     hold_left;

  matrix2x2_fixed_alu_core u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .x_a(x_a), .x_b(x_b), .x_c(x_c), .x_d(x_d),
    .y_a(y_a), .y_b(y_b), .y_c(y_c), .y_d(y_d),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_a(out_a), .out_b(out_b), .out_c(out_c), .out_d(out_d),
    .singular(singular), .divide_fault(divide_fault),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- arithmetic predictor ----------------

  function automatic logic signed [DATA_W-1:0] clamp_word(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return SAT_MAX;
    if (v < -66'sd2147483648) return SAT_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Round a sum of two double-width products, ties up, then saturate
  function automatic logic signed [DATA_W-1:0] round_pair(input logic signed [65:0] p,
                                                           input logic signed [65:0] q);
    logic signed [67:0] v;
    v = 68'(p) + 68'(q) + (68'sd1 <<< (FRAC_BITS - 1));
    v = v >>> FRAC_BITS;
    return clamp_word(v[65:0]);
  endfunction

  function automatic logic signed [65:0] wide_mul(input logic signed [DATA_W-1:0] p,
                                                   input logic signed [DATA_W-1:0] q);
    return 66'(p) * 66'(q);
  endfunction

  // Quotient (num << shift) / den, rounded on magnitude, ties away from zero
  function automatic logic signed [DATA_W-1:0] round_quot(input logic signed [65:0] num,
                                                           input int shift,
                                                           input logic signed [65:0] den,
                                                           inout bit fault);
    logic [127:0] nm, dm, quo, rem;
    bit neg;
    nm  = (num < 0) ? 128'(-num) : 128'(num);
    dm  = (den < 0) ? 128'(-den) : 128'(den);
    neg = (num < 0) != (den < 0);
    if (dm == 0) begin
      fault = 1'b1;
      return (num > 0) ? SAT_MAX : ((num < 0) ? SAT_MIN : '0);
    end
    if (nm == 0) return '0;
    quo = (nm << shift) / dm;
    rem = (nm << shift) % dm;
    if (rem >= dm - rem) quo = quo + 1;
    if (quo > 128'h8000_0000) return neg ? SAT_MIN : SAT_MAX;
    if (neg) return -quo[DATA_W-1:0];
    if (quo > 128'h7FFF_FFFF) return SAT_MAX;
    return quo[DATA_W-1:0];
  endfunction

  function automatic logic signed [65:0] det_exact(input mat_t m);
    return wide_mul(m[0], m[3]) - wide_mul(m[1], m[2]);
  endfunction

  function automatic bit below_threshold(input logic signed [65:0] det,
                                         input logic [THR_W-1:0] thr);
    logic [65:0] mag;
    mag = (det < 0) ? 66'(-det) : 66'(det);
    return mag < (66'(thr) << FRAC_BITS);
  endfunction

  function automatic void invert_into(input mat_t m, output mat_t r, inout bit fault);
    logic signed [65:0] det;
    det  = det_exact(m);
    r[0] = round_quot(66'(m[3]), 2 * FRAC_BITS, det, fault);
    r[1] = round_quot(-66'(m[1]), 2 * FRAC_BITS, det, fault);
    r[2] = round_quot(-66'(m[2]), 2 * FRAC_BITS, det, fault);
    r[3] = round_quot(66'(m[0]), 2 * FRAC_BITS, det, fault);
  endfunction

  function automatic void product_into(input mat_t x, input mat_t m, output mat_t r);
    r[0] = round_pair(wide_mul(x[0], m[0]), wide_mul(x[1], m[2]));
    r[1] = round_pair(wide_mul(x[0], m[1]), wide_mul(x[1], m[3]));
    r[2] = round_pair(wide_mul(x[2], m[0]), wide_mul(x[3], m[2]));
    r[3] = round_pair(wide_mul(x[2], m[1]), wide_mul(x[3], m[3]));
  endfunction

  function automatic matrix_result_t compute_matrix_op(input logic [3:0] op, input mat_t x,
                                                       input mat_t y,
                                                       input logic [THR_W-1:0] thr);
    mat_t r, t;
    bit sing, fault;
    matrix_result_t res;
    sing  = 1'b0;
    fault = 1'b0;
    for (int i = 0; i < 4; i++) r[i] = '0;
    case (op)
      OP_ADD:   for (int i = 0; i < 4; i++) r[i] = clamp_word(66'(x[i]) + 66'(y[i]));
      OP_SUB:   for (int i = 0; i < 4; i++) r[i] = clamp_word(66'(x[i]) - 66'(y[i]));
      OP_SCALE: for (int i = 0; i < 4; i++) r[i] = round_pair(wide_mul(x[i], y[0]), '0);
      OP_DIV: begin
        for (int i = 0; i < 4; i++) r[i] = round_quot(66'(x[i]), FRAC_BITS, 66'(y[0]), fault);
      end
      OP_MVEC: begin
        r[0] = round_pair(wide_mul(x[0], y[0]), wide_mul(x[1], y[1]));
        r[1] = round_pair(wide_mul(x[2], y[0]), wide_mul(x[3], y[1]));
      end
      OP_MMUL: product_into(x, y, r);
      OP_INV: begin
        sing = below_threshold(det_exact(x), thr);
        invert_into(x, r, fault);
      end
      OP_XINVY: begin
        sing = below_threshold(det_exact(y), thr);
        invert_into(y, t, fault);
        product_into(x, t, r);
      end
      OP_SING: sing = below_threshold(det_exact(x), thr);
      default: ;
    endcase
    res.op    = op;
    res.a     = r[0];
    res.b     = r[1];
    res.c     = r[2];
    res.d     = r[3];
    res.sing  = sing;
    res.fault = fault;
    return res;
  endfunction

  // ---------------- sender side ----------------

  task automatic send_item(input logic [3:0] op, input mat_t x, input mat_t y);
    while (!quiet && $urandom_range(0, 99) < 19) begin
      @(negedge clk);
      in_valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid  = 1'b1;
    operation = op;
    x_a = x[0]; x_b = x[1]; x_c = x[2]; x_d = x[3];
    y_a = y[0]; y_b = y[1]; y_c = y[2]; y_d = y[3];
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_results.push_back(compute_matrix_op(op, x, y, thr_shadow));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    drain_results();
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = ADDR_THRESHOLD; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    thr_shadow = value[THR_W-1:0];
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return SAT_MIN;
      1: return SAT_MAX;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
      4, 5, 6: return $signed(32'($urandom_range(0, 32'h0007_FFFF))) - 32'sh0004_0000;
      default: return $urandom;
    endcase
  endfunction

  // Rows proportional by a small factor, nudged by a few LSBs
  function automatic void near_singular(output mat_t m);
    int k;
    k    = $urandom_range(0, 6) - 3;
    m[0] = $signed(32'($urandom_range(0, 32'h0003_FFFF))) - 32'sh0002_0000;
    m[1] = $signed(32'($urandom_range(0, 32'h0003_FFFF))) - 32'sh0002_0000;
    m[2] = m[0] * k + $signed(32'($urandom_range(0, 6))) - 3;
    m[3] = m[1] * k + $signed(32'($urandom_range(0, 6))) - 3;
  endfunction

  task automatic send_random();
    mat_t x, y;
    logic [3:0] op;
    for (int i = 0; i < 4; i++) begin
      x[i] = pick_word();
      y[i] = pick_word();
    end
    op = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    if ((op == OP_INV || op == OP_SING) && $urandom_range(0, 2) == 0) near_singular(x);
    if (op == OP_XINVY && $urandom_range(0, 2) == 0) near_singular(y);
    if (op == OP_DIV && $urandom_range(0, 4) == 0) y[0] = '0;
    send_item(op, x, y);
  endtask

  // ---------------- receiver side ----------------

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 19);
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    matrix_result_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{op: 4'd0, a: out_a, b: out_b, c: out_c, d: out_d,
              sing: singular, fault: divide_fault};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want   = pending_results.pop_front();
        got.op = want.op;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed();
    mat_t x, y, z;
    z = '{default: '0};
    x = '{SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN};
    y = '{SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN};
    // Every code, extremes on both matrices
    for (int op = 0; op < 16; op++) send_item(4'(op), x, y);
    // Division by zero with mixed signs
    send_item(OP_DIV, '{32'sh0001_0000, -32'sh0002_0000, '0, SAT_MAX}, z);
    // Singular X and Y: zero determinant
    send_item(OP_INV, '{32'sh0001_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sh0004_0000}, z);
    send_item(OP_XINVY, x, z);
    send_item(OP_SING, z, z);
    // Identity, rounding ties and a saturating matrix-vector product
    send_item(OP_INV, '{32'sh0001_0000, '0, '0, 32'sh0001_0000}, z);
    send_item(OP_SCALE, '{32'sd1, -32'sd1, 32'sd3, -32'sd3}, '{32'sh0000_8000, 0, 0, 0});
    send_item(OP_DIV, '{32'sd1, -32'sd1, 32'sd3, -32'sd3}, '{32'sh0002_0000, 0, 0, 0});
    send_item(OP_MVEC, '{SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN}, '{SAT_MIN, SAT_MIN, 0, 0});
  endtask

  task automatic test_threshold_sweep();
    logic [31:0] settings [4];
    settings = '{32'd0, 32'h7FFF_FFFF, 32'd1, $urandom};
    foreach (settings[i]) begin
      write_threshold(settings[i]);
      repeat (60) send_random();
    end
    write_threshold(32'd66);
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    @(negedge clk);
    hold_req = 1'b1;
    repeat (120) send_random();
    quiet = 1'b0;
    drain_results();
  endtask

  task automatic test_random();
    for (int i = 0; i < 470; i++) begin
      quiet = (i >= 150 && i < 250);
      send_random();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; operation = '0;
    x_a = '0; x_b = '0; x_c = '0; x_d = '0;
    y_a = '0; y_b = '0; y_c = '0; y_d = '0;
    out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    thr_shadow = THR_RESET;
    mismatches = 0; cycle_count = 0; quiet = 1'b0; hold_req = 1'b0; hold_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_threshold_sweep();
    test_backpressure();
    test_random();
    drain_results();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
